// ----- rtl/core/email_address_spotter_assert.svh -----
`ifndef EMAIL_ADDRESS_SPOTTER_ASSERT_SVH
`define EMAIL_ADDRESS_SPOTTER_ASSERT_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define EAS_ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("email_address_spotter check failed");

// Implication checked in the cycle after the antecedent holds.
`define EAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    `EAS_ASSERT_PROP(label, clk, rstn, (ante) |=> (cons))

`endif

// ----- rtl/core/eas_pkg.sv -----
package eas_pkg;

    localparam int OUT_OFF_W = 10;

    localparam logic [1:0] KIND_AT      = 2'd0;
    localparam logic [1:0] KIND_BR_AT   = 2'd1;
    localparam logic [1:0] KIND_BR_HASH = 2'd2;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        BR_IDLE,
        BR_OPEN,
        BR_A,
        BR_AT,
        BR_HASH
    } bracket_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  marker_kind;
        logic [9:0]  start_offset;
        logic [9:0]  end_offset;
        logic [31:0] match_number;
    } out_item_t;

    typedef struct packed {
        logic is_word;
        logic is_dot;
        logic is_lbr;
        logic is_rbr;
        logic is_at;
        logic is_hash;
        logic is_a;
        logic is_t;
        logic last;
    } byte_class_t;

endpackage

// ----- rtl/core/email_address_spotter.sv -----
// Spots e-mail addresses in a byte stream, one text byte per input item.
// The input channel (s_valid, s_ready, s_payload) carries a data byte and a
// line end flag that marks the last byte of a line. Separators are '@',
// "[at]" and "[#]"; the domain after the separator must contain a dot.
// The result channel (m_valid, m_ready, m_payload) carries one item per hit:
// separator kind, start and end offsets in the line, and a running count.
// A hit is reported on the byte that closes its domain, or on the line end
// byte, so results come out in order of position.
// Throughput is one byte per cycle while the receiver takes results. A
// classified byte goes through a two entry queue into the scanner, whose
// output register holds the result; the byte is registered in the queue,
// and its result in the output register. When the receiver stalls with a
// result pending, the scanner stops, the queue fills and s_ready drops.
// Offsets saturate at LINE_LEN-1 on long lines and are reported modulo 1024.
// Reset clears the line offset, the word, separator and domain tracking, the
// queue and the hit count; no result is pending afterwards.
module email_address_spotter #(
    parameter int LINE_LEN = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  eas_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output eas_pkg::out_item_t m_payload
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;
    eas_pkg::byte_class_t q_in_item;
    eas_pkg::byte_class_t q_out_item;

    eas_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    eas_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_out_item)
    );

    eas_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ----- rtl/core/eas_front.sv -----
module eas_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  eas_pkg::in_item_t    s_payload,
    input  logic                 q_full,
    output logic                 q_push,
    output eas_pkg::byte_class_t q_item
);

    logic [7:0] b;

    assign b       = s_payload.data_byte;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.is_word = (b >= eas_pkg::CH_LOW_A && b <= eas_pkg::CH_LOW_Z) ||
                         (b >= eas_pkg::CH_UP_A && b <= eas_pkg::CH_UP_Z) ||
                         (b >= eas_pkg::CH_ZERO && b <= eas_pkg::CH_NINE) ||
                         b == eas_pkg::CH_DOT || b == eas_pkg::CH_UNDER ||
                         b == eas_pkg::CH_DASH;
        q_item.is_dot  = (b == eas_pkg::CH_DOT);
        q_item.is_lbr  = (b == eas_pkg::CH_LBR);
        q_item.is_rbr  = (b == eas_pkg::CH_RBR);
        q_item.is_at   = (b == eas_pkg::CH_AT);
        q_item.is_hash = (b == eas_pkg::CH_HASH);
        q_item.is_a    = (b == eas_pkg::CH_LOW_A);
        q_item.is_t    = (b == eas_pkg::CH_LOW_T);
        q_item.last    = s_payload.line_end;
    end

endmodule

// ----- rtl/core/eas_queue.sv -----
module eas_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  eas_pkg::byte_class_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output eas_pkg::byte_class_t pop_item
);

    eas_pkg::byte_class_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/eas_back.sv -----
module eas_back #(
    parameter int LINE_LEN = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  eas_pkg::byte_class_t q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output eas_pkg::out_item_t   m_payload
);

    localparam int OFF_W = $clog2(LINE_LEN);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(LINE_LEN - 1);

    logic [OFF_W-1:0]        offset_reg, offset_next;
    logic [OFF_W-1:0]        word_start_reg, word_start_next;
    logic                    in_word_reg, in_word_next;
    eas_pkg::bracket_state_t phase_reg, phase_next;
    logic [OFF_W-1:0]        br_start_reg, br_start_next;
    logic [1:0]              pkind_reg, pkind_next;
    logic [OFF_W-1:0]        pstart_reg, pstart_next;
    logic                    dom_open_reg, dom_open_next;
    logic                    dot_reg, dot_next;
    logic [31:0]             count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    eas_pkg::out_item_t      m_payload_reg;

    logic                    hit;
    logic                    opened;
    logic [1:0]              hit_kind;
    logic [OFF_W-1:0]        hit_start;
    logic [OFF_W-1:0]        hit_end;
    logic [OFF_W-1:0]        local_start;
    logic [OFF_W+9:0]        start_wide;
    logic [OFF_W+9:0]        end_wide;

    assign q_pop       = q_valid && (!m_valid_reg || m_ready);
    assign m_valid     = m_valid_reg;
    assign m_payload   = m_payload_reg;
    assign local_start = in_word_reg ? word_start_reg : offset_reg;
    assign start_wide  = {{eas_pkg::OUT_OFF_W{1'b0}}, hit_start};
    assign end_wide    = {{eas_pkg::OUT_OFF_W{1'b0}}, hit_end};

    always_comb begin
        offset_next     = offset_reg;
        word_start_next = word_start_reg;
        in_word_next    = in_word_reg;
        phase_next      = eas_pkg::BR_IDLE;
        br_start_next   = br_start_reg;
        pkind_next      = pkind_reg;
        pstart_next     = pstart_reg;
        dom_open_next   = dom_open_reg;
        dot_next        = dot_reg;
        hit             = 1'b0;
        opened          = 1'b0;
        hit_kind        = pkind_reg;
        hit_start       = pstart_reg;
        hit_end         = offset_reg - OFF_W'(1);

        if (dom_open_reg) begin
            if (q_item.is_word) begin
                if (q_item.is_dot) begin
                    dot_next = 1'b1;
                end
            end else begin
                if (dot_reg && offset_reg != '0) begin
                    hit = 1'b1;
                end
                dom_open_next = 1'b0;
                dot_next      = 1'b0;
            end
        end

        unique case (phase_reg)
            eas_pkg::BR_OPEN: begin
                if (q_item.is_a) begin
                    phase_next = eas_pkg::BR_A;
                end else if (q_item.is_hash) begin
                    phase_next = eas_pkg::BR_HASH;
                end
            end
            eas_pkg::BR_A: begin
                if (q_item.is_t) begin
                    phase_next = eas_pkg::BR_AT;
                end
            end
            eas_pkg::BR_AT, eas_pkg::BR_HASH: begin
                if (q_item.is_rbr) begin
                    pkind_next    = (phase_reg == eas_pkg::BR_AT) ?
                                    eas_pkg::KIND_BR_AT : eas_pkg::KIND_BR_HASH;
                    pstart_next   = br_start_reg;
                    dom_open_next = 1'b1;
                    dot_next      = 1'b0;
                    opened        = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (!opened && phase_next == eas_pkg::BR_IDLE) begin
            if (q_item.is_lbr) begin
                phase_next    = eas_pkg::BR_OPEN;
                br_start_next = local_start;
            end else if (q_item.is_at) begin
                pkind_next    = eas_pkg::KIND_AT;
                pstart_next   = local_start;
                dom_open_next = 1'b1;
                dot_next      = 1'b0;
            end
        end

        if (q_item.is_word) begin
            if (!in_word_reg) begin
                in_word_next    = 1'b1;
                word_start_next = offset_reg;
            end
        end else begin
            in_word_next = 1'b0;
        end

        if (q_item.last) begin
            if (dom_open_next && dot_next && !hit) begin
                hit       = 1'b1;
                hit_kind  = pkind_next;
                hit_start = pstart_next;
                hit_end   = offset_reg;
            end
            offset_next     = '0;
            word_start_next = '0;
            in_word_next    = 1'b0;
            phase_next      = eas_pkg::BR_IDLE;
            br_start_next   = '0;
            dom_open_next   = 1'b0;
            dot_next        = 1'b0;
        end else if (offset_reg < OFF_MAX) begin
            offset_next = offset_reg + OFF_W'(1);
        end

        count_next   = hit ? count_reg + 32'd1 : count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (hit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg     <= '0;
            word_start_reg <= '0;
            in_word_reg    <= 1'b0;
            phase_reg      <= eas_pkg::BR_IDLE;
            br_start_reg   <= '0;
            pkind_reg      <= eas_pkg::KIND_AT;
            pstart_reg     <= '0;
            dom_open_reg   <= 1'b0;
            dot_reg        <= 1'b0;
            count_reg      <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else if (q_pop) begin
            offset_reg     <= offset_next;
            word_start_reg <= word_start_next;
            in_word_reg    <= in_word_next;
            phase_reg      <= phase_next;
            br_start_reg   <= br_start_next;
            pkind_reg      <= pkind_next;
            pstart_reg     <= pstart_next;
            dom_open_reg   <= dom_open_next;
            dot_reg        <= dot_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end else if (m_ready) begin
            m_valid_reg    <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && hit) begin
            m_payload_reg.marker_kind  <= hit_kind;
            m_payload_reg.start_offset <= start_wide[eas_pkg::OUT_OFF_W-1:0];
            m_payload_reg.end_offset   <= end_wide[eas_pkg::OUT_OFF_W-1:0];
            m_payload_reg.match_number <= count_next;
        end
    end

endmodule

// ----- rtl/core/eas_checker.sv -----
`include "email_address_spotter_assert.svh"

module eas_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input eas_pkg::in_item_t  s_payload,
    input logic               m_valid,
    input logic               m_ready,
    input eas_pkg::out_item_t m_payload
);

    logic [31:0] exp_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_num_reg <= 32'd1;
        end else if (m_valid && m_ready) begin
            exp_num_reg <= exp_num_reg + 32'd1;
        end
    end

    `EAS_ASSERT_NEXT(a_in_item_holds, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_payload))
    `EAS_ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    `EAS_ASSERT_NEXT(a_out_payload_holds, aclk, aresetn, m_valid && !m_ready,
        $stable(m_payload))
    `EAS_ASSERT_PROP(a_number_in_sequence, aclk, aresetn,
        m_valid |-> m_payload.match_number == exp_num_reg)
    `EAS_ASSERT_PROP(a_kind_known, aclk, aresetn,
        m_valid |-> m_payload.marker_kind <= eas_pkg::KIND_BR_HASH)

endmodule

bind email_address_spotter eas_checker u_eas_checker (.*);

// ----- sim/address_hit_checker.sv -----
module address_hit_checker #(
    parameter int LINE_LEN = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  eas_pkg::in_item_t  s_payload,
    input  logic               m_valid,
    input  logic               m_ready,
    input  eas_pkg::out_item_t m_payload,
    output int                 mismatches,
    output int                 hits_due,
    output int                 hits_checked
);
    import eas_pkg::*;

    logic [9:0]     line_pos;
    logic [9:0]     word_begin;
    logic           in_token;
    bracket_state_t bracket;
    logic [9:0]     bracket_begin;
    logic [1:0]     hit_kind;
    logic [9:0]     hit_begin;
    logic           domain_live;
    logic           domain_dotted;
    logic [31:0]    hit_count;
    out_item_t      awaited_hits[$];

    function automatic bit is_word_char(input logic [7:0] b);
        return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
               (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_UNDER ||
               b == CH_DASH;
    endfunction

    task automatic clear_scan;
        line_pos = '0;
        word_begin = '0;
        in_token = 1'b0;
        bracket = BR_IDLE;
        bracket_begin = '0;
        domain_live = 1'b0;
        domain_dotted = 1'b0;
    endtask

    task automatic record_hit(input logic [9:0] end_pos);
        out_item_t hit;
        hit_count = hit_count + 32'd1;
        hit.marker_kind = hit_kind;
        hit.start_offset = hit_begin;
        hit.end_offset = end_pos;
        hit.match_number = hit_count;
        awaited_hits.push_back(hit);
    endtask

    task automatic scan_byte(input in_item_t item);
        logic [7:0]     b;
        logic [9:0]     pos;
        logic [9:0]     local_begin;
        bit             wc;
        bit             emitted;
        bit             opened;
        bracket_state_t next_br;
        b = item.data_byte;
        pos = line_pos;
        wc = is_word_char(b);
        local_begin = in_token ? word_begin : pos;
        emitted = 1'b0;
        opened = 1'b0;
        next_br = BR_IDLE;

        if (domain_live) begin
            if (wc) begin
                if (b == CH_DOT) domain_dotted = 1'b1;
            end else begin
                if (domain_dotted && pos != 10'd0) begin
                    record_hit(pos - 10'd1);
                    emitted = 1'b1;
                end
                domain_live = 1'b0;
                domain_dotted = 1'b0;
            end
        end

        case (bracket)
            BR_OPEN: begin
                if (b == CH_LOW_A) next_br = BR_A;
                else if (b == CH_HASH) next_br = BR_HASH;
            end
            BR_A: begin
                if (b == CH_LOW_T) next_br = BR_AT;
            end
            BR_AT, BR_HASH: begin
                if (b == CH_RBR) begin
                    hit_kind = (bracket == BR_AT) ? KIND_BR_AT : KIND_BR_HASH;
                    hit_begin = bracket_begin;
                    domain_live = 1'b1;
                    domain_dotted = 1'b0;
                    opened = 1'b1;
                end
            end
            default: begin
            end
        endcase
        bracket = next_br;
        if (!opened && next_br == BR_IDLE) begin
            if (b == CH_LBR) begin
                bracket = BR_OPEN;
                bracket_begin = local_begin;
            end else if (b == CH_AT) begin
                hit_kind = KIND_AT;
                hit_begin = local_begin;
                domain_live = 1'b1;
                domain_dotted = 1'b0;
            end
        end

        if (wc) begin
            if (!in_token) begin
                in_token = 1'b1;
                word_begin = pos;
            end
        end else begin
            in_token = 1'b0;
        end

        if (item.line_end) begin
            if (domain_live && domain_dotted && !emitted) record_hit(pos);
            clear_scan();
        end else if (pos < LINE_LEN - 1) begin
            line_pos = pos + 10'd1;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, want, got);
        end
    endtask

    task automatic check_hit(input out_item_t got);
        out_item_t want;
        if (awaited_hits.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got kind %0d start %0d",
                     $time, got.marker_kind, got.start_offset);
            $display("%0t: unexpected result continued, end %0d number %0d",
                     $time, got.end_offset, got.match_number);
        end else begin
            want = awaited_hits.pop_front();
            compare_field("marker_kind", want.marker_kind, got.marker_kind);
            compare_field("start_offset", want.start_offset, got.start_offset);
            compare_field("end_offset", want.end_offset, got.end_offset);
            compare_field("match_number", want.match_number, got.match_number);
            hits_checked++;
        end
    endtask

    initial begin
        mismatches = 0;
        hits_due = 0;
        hits_checked = 0;
        hit_kind = KIND_AT;
        hit_begin = '0;
        hit_count = '0;
        clear_scan();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scan();
            hit_kind = KIND_AT;
            hit_begin = '0;
            hit_count = '0;
            awaited_hits.delete();
        end else begin
            if (m_valid && m_ready) check_hit(m_payload);
            if (s_valid && s_ready) scan_byte(s_payload);
        end
        hits_due = awaited_hits.size();
    end

endmodule

// ----- sim/tb.sv -----
module tb;
    import eas_pkg::*;

    localparam int LINE_LEN        = 1024;
    localparam int DIRECTED_BYTES  = 25;
    localparam int RANDOM_BYTES    = 300;
    localparam int TAIL_BYTES      = 200;
    localparam int DENSE_BYTES     = 60;
    localparam int LONG_LINE_BYTES = 1030;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 500000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_payload;

    int mismatches;
    int hits_due;
    int hits_checked;
    int bytes_sent = 0;
    int lines_sent = 0;
    int cycles = 0;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;
    bit quiet_tail = 1'b0;
    logic [7:0] line_bytes[$];

    always #5 aclk = ~aclk;

    email_address_spotter #(
        .LINE_LEN (LINE_LEN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    address_hit_checker #(
        .LINE_LEN (LINE_LEN)
    ) hit_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload),
        .mismatches   (mismatches),
        .hits_due     (hits_due),
        .hits_checked (hits_checked)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, hits_due);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_done = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        s_payload.data_byte <= b;
        s_payload.line_end <= last;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic pause_sender(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic drain_hits;
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (hits_due == 0);
    endtask

    task automatic send_line(input bit gaps);
        for (int i = 0; i < line_bytes.size(); i++) begin
            if (gaps && !quiet_tail && $urandom_range(0, 7) == 0)
                pause_sender($urandom_range(1, 6));
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
        end
        lines_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 64);
        if (r < 26) return CH_LOW_A + r;
        if (r < 52) return CH_UP_A + (r - 26);
        if (r < 62) return CH_ZERO + (r - 52);
        if (r == 62) return CH_DOT;
        if (r == 63) return CH_UNDER;
        return CH_DASH;
    endfunction

    task automatic add_word(input int len, input bit dotted);
        for (int i = 0; i < len; i++) line_bytes.push_back(word_char());
        if (dotted && len > 0)
            line_bytes[line_bytes.size() - 1 - $urandom_range(0, len - 1)] = CH_DOT;
    endtask

    task automatic add_address;
        add_word(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6), 1'b0);
        case ($urandom_range(0, 2))
            0: begin
                line_bytes.push_back(CH_AT);
            end
            1: begin
                line_bytes.push_back(CH_LBR);
                line_bytes.push_back(CH_LOW_A);
                line_bytes.push_back(CH_LOW_T);
                line_bytes.push_back(CH_RBR);
            end
            default: begin
                line_bytes.push_back(CH_LBR);
                line_bytes.push_back(CH_HASH);
                line_bytes.push_back(CH_RBR);
            end
        endcase
        add_word($urandom_range(1, 8), $urandom_range(0, 4) != 0);
    endtask

    task automatic add_broken_bracket;
        line_bytes.push_back(CH_LBR);
        case ($urandom_range(0, 3))
            1: begin
                line_bytes.push_back(CH_LOW_A);
            end
            2: begin
                line_bytes.push_back(CH_LOW_A);
                line_bytes.push_back(CH_LOW_T);
            end
            3: begin
                line_bytes.push_back(CH_HASH);
            end
            default: begin
            end
        endcase
        line_bytes.push_back($urandom_range(0, 255));
    endtask

    // Mostly well-formed addresses with random content; the rest is bracket
    // fragments and raw bytes. Tokens are often glued together without a gap.
    task automatic build_line(input int target, input bit dense);
        int pick;
        line_bytes.delete();
        while (line_bytes.size() < target) begin
            pick = $urandom_range(0, 99);
            if (dense || pick < 65) begin
                add_address();
            end else if (pick < 80) begin
                add_broken_bracket();
            end else begin
                repeat ($urandom_range(1, 4)) line_bytes.push_back($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) line_bytes.push_back(8'h20);
            else if (pick < 7) line_bytes.push_back($urandom_range(0, 255));
        end
    endtask

    task automatic send_random_lines(input int stop_at);
        while (bytes_sent < stop_at) begin
            if (stop_at == DIRECTED_BYTES + RANDOM_BYTES + DENSE_BYTES + LONG_LINE_BYTES &&
                stop_at - bytes_sent <= TAIL_BYTES)
                quiet_tail = 1'b1;
            build_line($urandom_range(1, 60), 1'b0);
            send_line(1'b1);
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Chained hits, empty local part, broken bracket, closing on a
        // zero byte, all-ones byte, and a domain without a dot at line end.
        line_bytes.delete();
        add_text("@b.c[#]d.e");
        send_line(1'b1);
        line_bytes.delete();
        add_text("x[a[at]y.z");
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        send_line(1'b1);
        line_bytes.delete();
        add_text("q@r");
        send_line(1'b1);

        send_random_lines(DIRECTED_BYTES + RANDOM_BYTES / 2);

        // Receiver holds off while a dense run of addresses keeps coming.
        hold_off_req = 1'b1;
        build_line(DENSE_BYTES, 1'b1);
        send_line(1'b0);
        wait (hold_off_done);
        drain_hits();

        // One line long enough for the offsets to saturate.
        build_line(LONG_LINE_BYTES, 1'b0);
        send_line(1'b1);

        send_random_lines(DIRECTED_BYTES + RANDOM_BYTES + DENSE_BYTES + LONG_LINE_BYTES);
        drain_hits();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d lines; %0d address hits compared over all three",
                 bytes_sent, lines_sent, hits_checked);
        $display("separator forms, with a saturated long line and a %0d-cycle receiver hold-off.",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && hits_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived.", mismatches, hits_due);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
